[src/swhc_pkg.sv]
package swhc_pkg;

    localparam int FIFO_DEPTH   = 512;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int OCC_W        = $clog2(FIFO_DEPTH + 1);
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 16;
    localparam int TOTAL_W      = 25;
    localparam int WIN_W        = 10;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(300);
    localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(512);
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

    typedef enum logic {
        OP_HIT   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // one classified request on its way from front to back
    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] event_time;
        logic              order_error;
    } job_t;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WIN_W'(1);
        end else if (w > WINDOW_MAX) begin
            r = WINDOW_MAX;
        end
        return r;
    endfunction

endpackage

[src/sliding_window_hit_counter_core.sv]
// Sliding window hit counter. Each request on the slave side is a hit
// (tuser 0) or a query (tuser 1) stamped with a time in whole seconds on
// tdata. Hits are kept as a FIFO of distinct seconds, up to 512 of them,
// each with a count that saturates at 65535; a hit for a new second while
// the FIFO is full is dropped. A query returns the number of hits in
// (time - window, time] and a sticky flag that reports any request whose
// time went backwards since reset (such a request takes the last time seen).
// The window (1..512 seconds, reset 300; 0 acts as 1 and larger values as
// 512) is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Expiry
// is paced by the single read port of the second memory, which delivers one
// head entry per cycle. A four-deep queue lets the front keep taking requests
// while the back end expires entries, and a query result waits in an output
// register without stalling intake.
module sliding_window_hit_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,     // window_seconds
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,         // [31:0] event_time
    input  logic        s_tuser,         // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,         // [24:0] hit_count, [31:25] zero
    output logic        m_tuser          // [0] order_error
);
    import swhc_pkg::*;

    logic [WIN_W-1:0]   window_reg;
    logic [WIN_W-1:0]   window_eff;
    logic               push_valid, push_ready;
    job_t               push_job;
    logic               pop_valid, pop_ready;
    job_t               pop_job;
    logic [TOTAL_W-1:0] hit_count;

    // hold the window register; writes must come only while idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    assign window_eff = clamp_window(window_reg);

    // front: accept and classify, fix up out-of-order times
    swhc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_time     (s_tdata),
        .s_op       (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // decouple front intake from back-end expiry
    swhc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // back: expire, record hits, answer queries
    swhc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window        (window_eff),
        .job_valid     (pop_valid),
        .job_take      (pop_ready),
        .job           (pop_job),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_hit_count   (hit_count),
        .m_order_error (m_tuser)
    );

    assign m_tdata = {(32 - TOTAL_W)'(0), hit_count};

endmodule

[src/swhc_front.sv]
module swhc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [swhc_pkg::TIME_W-1:0] s_time,
    input  logic                      s_op,
    output logic                      push_valid,
    input  logic                      push_ready,
    output swhc_pkg::job_t            push_job
);
    import swhc_pkg::*;

    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              flag_reg, flag_next;
    logic              late;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign late       = (s_time < last_time_reg);

    always_comb begin
        last_time_next = last_time_reg;
        flag_next      = flag_reg;
        // a time that goes backwards takes the last time seen
        push_job.op          = op_t'(s_op);
        push_job.event_time  = late ? last_time_reg : s_time;
        push_job.order_error = flag_reg | late;
        if (s_tvalid && push_ready) begin
            last_time_next = push_job.event_time;
            flag_next      = push_job.order_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            flag_reg      <= 1'b0;
        end else begin
            last_time_reg <= last_time_next;
            flag_reg      <= flag_next;
        end
    end

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |=> flag_reg)
        else $error("order flag cleared without reset");

endmodule

[src/swhc_queue.sv]
module swhc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  swhc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output swhc_pkg::job_t pop_job
);
    import swhc_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

[src/swhc_back.sv]
module swhc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [swhc_pkg::WIN_W-1:0]  window,
    input  logic                        job_valid,
    output logic                        job_take,
    input  swhc_pkg::job_t              job,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swhc_pkg::TOTAL_W-1:0] m_hit_count,
    output logic                        m_order_error
);
    import swhc_pkg::*;

    logic [TIME_W-1:0] mem_stamp [FIFO_DEPTH];
    logic [CNT_W-1:0]  mem_count [FIFO_DEPTH];

    back_state_t        state_reg, state_next;
    job_t               cur_reg, cur_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   last_idx_reg, last_idx_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TIME_W-1:0]  last_stamp_reg, last_stamp_next;
    logic [CNT_W-1:0]   last_count_reg, last_count_next;
    logic [TIME_W-1:0]  rd_stamp_reg;
    logic [CNT_W-1:0]   rd_count_reg;
    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_count_reg, out_count_next;
    logic               out_flag_reg, out_flag_next;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [TIME_W-1:0]  wr_stamp;
    logic [CNT_W-1:0]   wr_count;
    logic               expire;
    logic               out_free;

    assign m_tvalid      = out_valid_reg;
    assign m_hit_count   = out_count_reg;
    assign m_order_error = out_flag_reg;
    assign out_free      = !out_valid_reg || m_tready;

    // head entry is stale once stamp + window reaches the current time
    assign expire = (occ_reg != '0) &&
        (({1'b0, rd_stamp_reg} + (TIME_W+1)'(window)) <= {1'b0, cur_reg.event_time});

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        last_idx_next   = last_idx_reg;
        occ_next        = occ_reg;
        total_next      = total_reg;
        last_stamp_next = last_stamp_reg;
        last_count_next = last_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_count_next  = out_count_reg;
        out_flag_next   = out_flag_reg;
        job_take        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_stamp        = cur_reg.event_time;
        wr_count        = CNT_W'(1);

        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_take   = 1'b1;
                    cur_next   = job;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (expire) begin
                    // pop one entry; the read port fetches the new head
                    total_next = total_reg - TOTAL_W'(rd_count_reg);
                    head_next  = head_reg + PTR_W'(1);
                    occ_next   = occ_reg - OCC_W'(1);
                end else if (cur_reg.op == OP_HIT) begin
                    state_next = BK_IDLE;
                    if (occ_reg != '0 && last_stamp_reg == cur_reg.event_time) begin
                        if (last_count_reg != COUNT_MAX) begin
                            wr_en           = 1'b1;
                            wr_addr         = last_idx_reg;
                            wr_count        = last_count_reg + CNT_W'(1);
                            last_count_next = wr_count;
                            total_next      = total_reg + TOTAL_W'(1);
                        end
                    end else if (occ_reg != OCC_W'(FIFO_DEPTH)) begin
                        wr_en           = 1'b1;
                        last_idx_next   = tail_reg;
                        last_stamp_next = cur_reg.event_time;
                        last_count_next = CNT_W'(1);
                        tail_next       = tail_reg + PTR_W'(1);
                        occ_next        = occ_reg + OCC_W'(1);
                        total_next      = total_reg + TOTAL_W'(1);
                    end
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = total_reg;
                    out_flag_next  = cur_reg.order_error;
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_stamp[wr_addr] <= wr_stamp;
            mem_count[wr_addr] <= wr_count;
        end
        rd_stamp_reg <= mem_stamp[head_next];
        rd_count_reg <= mem_count[head_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        last_idx_reg   <= last_idx_next;
        last_stamp_reg <= last_stamp_next;
        last_count_reg <= last_count_next;
        out_count_reg  <= out_count_next;
        out_flag_reg   <= out_flag_next;
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(FIFO_DEPTH))
        else $error("occupancy beyond fifo depth");

    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == '0) |-> (total_reg == '0))
        else $error("nonzero total with empty fifo");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg != OCC_W'(FIFO_DEPTH)) |->
            (tail_reg - head_reg == PTR_W'(occ_reg)))
        else $error("pointers disagree with occupancy");

endmodule
